FILE: hdl/wpt_pkg.sv
// Shared types and constants for the waveform pulse timing block.
package wpt_pkg;

  localparam int MAX_SAMPLES_DEF = 512;
  localparam int SCALE = 100;

  localparam logic [6:0] MARGIN_RST = 7'd5;
  localparam logic [7:0] LIMIT_RST = 8'd30;

  localparam logic REG_MARGIN = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef struct packed {
    logic [7:0] sample;
    logic       last;
  } wpt_in_t;

  typedef struct packed {
    logic [15:0] high_width_x100;
    logic [15:0] low_width_x100;
    logic [15:0] period_x100;
    logic [6:0]  duty_percent;
    logic [8:0]  cycle_count;
    logic [7:0]  window_max;
    logic [7:0]  window_min;
    logic        overflow;
  } wpt_out_t;

endpackage

FILE: hdl/wpt_div.sv
// Restoring divider, one quotient bit per cycle.
module wpt_div #(
  parameter int DVW = 16,
  parameter int DSW = 10
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [DSW-1:0] divisor,
  output logic           done,
  output logic [DVW-1:0] quotient
);

  localparam int CNTW = (DVW > 1) ? $clog2(DVW) : 1;

  logic           busy;
  logic [CNTW-1:0] cnt;
  logic [DVW-1:0] quo;
  logic [DSW-1:0] rem;
  logic [DSW-1:0] dsr;
  logic [DSW:0]   rem_sh;
  logic [DSW:0]   rem_sub;
  logic           take;

  assign rem_sh  = {rem, quo[DVW-1]};
  assign rem_sub = rem_sh - {1'b0, dsr};
  assign take    = (rem_sh >= {1'b0, dsr});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= take ? rem_sub[DSW-1:0] : rem_sh[DSW-1:0];
        quo <= {quo[DVW-2:0], take};
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(DVW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hdl/waveform_pulse_timing.sv
// Top level: sample window store, hysteresis pulse scan and averaging.
// Load: one sample per cycle while busy is low; the last sample starts the measurement.
// Scan: one memory read per cycle over the N stored samples.
// Divide: four serial divisions of a W-bit dividend, W = clog2(100 * MAX_SAMPLES + 1).
// Result strobes on done; the divisions are skipped unless 0 < cycles < limit.
// Synchronous reset clears the window and loads the register defaults; the sample
// memory is not cleared, only entries written in the current window are read.
module waveform_pulse_timing
  import wpt_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  wpt_in_t    item,
  output logic       done,
  output wpt_out_t   result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int FW  = $clog2(MAX_SAMPLES + 1);
  localparam int DVW = $clog2(SCALE * MAX_SAMPLES + 1);
  localparam int QW  = (DVW > 17) ? DVW : 17;
  localparam int CW  = (FW > 10) ? FW : 10;
  localparam int LW  = (FW > 8) ? FW : 8;

  localparam logic [1:0] EDGE_NONE = 2'b00;

  typedef enum logic [1:0] {S_LOAD, S_SCAN, S_DIV} state_t;
  typedef enum logic [1:0] {OP_HIGH, OP_LOW, OP_PER, OP_DUTY} op_t;

  state_t state;
  op_t    op;

  logic [7:0]    sample_mem [MAX_SAMPLES];
  logic [7:0]    rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;

  logic [FW-1:0] fill_count;
  logic [7:0]    running_max;
  logic [7:0]    running_min;
  logic          overflow_flag;
  logic [6:0]    margin;
  logic [7:0]    limit;

  logic [FW-1:0] rd_cnt;
  logic          s_vld;
  logic          s_first;
  logic          lvl;
  logic [FW-1:0] width;
  logic [1:0]    start_edge;
  logic [FW-1:0] sum_h, sum_l, tot_h, tot_l, cycles;
  logic [15:0]   hw, lw;
  logic          div_go;

  logic          accept, room, issue, scan_done, cyc_ok;
  logic [7:0]    mid;
  logic          curr_next;
  logic [1:0]    edge_code;
  logic          is_edge;
  logic [FW-1:0] width_inc, sum_h_next, sum_l_next, tot_sum;
  logic [DVW-1:0] dividend;
  logic [FW-1:0]  divisor;
  logic           div_done;
  logic [DVW-1:0] quotient;
  logic [QW-1:0]  q_ext;
  logic [15:0]    q_sat;
  logic [CW-1:0]  c_ext;
  logic [8:0]     cyc_sat;

  assign busy      = (state != S_LOAD);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign room      = (fill_count < FW'(MAX_SAMPLES));
  assign wr_en     = accept && room;
  assign issue     = (state == S_SCAN) && (rd_cnt < fill_count);
  assign rd_addr   = issue ? rd_cnt[AW-1:0] : fill_count[AW-1:0];
  assign scan_done = (state == S_SCAN) && (rd_cnt == fill_count) && !s_vld;
  assign cyc_ok    = (cycles != '0) && (LW'(cycles) < LW'(limit));

  assign mid = 8'((9'(running_max) + 9'(running_min)) >> 1);

  always_comb begin
    curr_next = lvl;
    if ({2'b00, rd_data} > 10'(mid) + 10'(margin)) curr_next = 1'b1;
    if (10'(rd_data) + 10'(margin) < 10'(mid)) curr_next = 1'b0;
  end

  assign edge_code  = {lvl, curr_next};
  assign is_edge    = !s_first && (lvl != curr_next);
  assign width_inc  = width + 1'b1;
  assign sum_h_next = curr_next ? sum_h : sum_h + width_inc;
  assign sum_l_next = curr_next ? sum_l + width_inc : sum_l;
  assign tot_sum    = tot_h + tot_l;

  always_comb begin
    dividend = DVW'(32'(SCALE) * 32'(tot_h));
    divisor  = cycles;
    case (op)
      OP_HIGH: begin
        dividend = DVW'(32'(SCALE) * 32'(tot_h));
        divisor  = cycles;
      end
      OP_LOW: begin
        dividend = DVW'(32'(SCALE) * 32'(tot_l));
        divisor  = cycles;
      end
      OP_PER: begin
        dividend = DVW'(32'(SCALE) * 32'(tot_sum));
        divisor  = cycles;
      end
      OP_DUTY: begin
        dividend = DVW'(32'(SCALE) * 32'(tot_h));
        divisor  = tot_sum;
      end
      default: begin
        dividend = '0;
        divisor  = cycles;
      end
    endcase
  end

  assign q_ext   = QW'(quotient);
  assign q_sat   = (|q_ext[QW-1:16]) ? 16'hFFFF : q_ext[15:0];
  assign c_ext   = CW'(cycles);
  assign cyc_sat = (c_ext > CW'(511)) ? 9'd511 : c_ext[8:0];

  wpt_div #(
    .DVW(DVW),
    .DSW(FW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sample_mem[fill_count[AW-1:0]] <= item.sample;
    end
    rd_data <= sample_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      op            <= OP_HIGH;
      fill_count    <= '0;
      running_max   <= 8'd0;
      running_min   <= 8'd255;
      overflow_flag <= 1'b0;
      margin        <= MARGIN_RST;
      limit         <= LIMIT_RST;
      s_vld         <= 1'b0;
      div_go        <= 1'b0;
      done          <= 1'b0;
    end else begin
      done   <= 1'b0;
      div_go <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MARGIN: margin <= cfg_data[6:0];
          REG_LIMIT:  limit  <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (room) begin
              fill_count <= fill_count + 1'b1;
              if (item.sample > running_max) running_max <= item.sample;
              if (item.sample < running_min) running_min <= item.sample;
            end else begin
              overflow_flag <= 1'b1;
            end
            if (item.last) begin
              state      <= S_SCAN;
              rd_cnt     <= '0;
              s_vld      <= 1'b0;
              lvl        <= 1'b0;
              width      <= '0;
              start_edge <= EDGE_NONE;
              sum_h      <= '0;
              sum_l      <= '0;
              tot_h      <= '0;
              tot_l      <= '0;
              cycles     <= '0;
            end
          end
        end
        S_SCAN: begin
          s_vld <= issue;
          if (issue) begin
            rd_cnt  <= rd_cnt + 1'b1;
            s_first <= (rd_cnt == '0);
          end
          if (s_vld) begin
            lvl <= curr_next;
            if (!s_first) begin
              if (is_edge) begin
                width <= '0;
                if (start_edge == EDGE_NONE) begin
                  start_edge <= edge_code;
                end else begin
                  sum_h <= sum_h_next;
                  sum_l <= sum_l_next;
                  if (start_edge == edge_code) begin
                    cycles <= cycles + 1'b1;
                    tot_h  <= sum_h_next;
                    tot_l  <= sum_l_next;
                  end
                end
              end else begin
                width <= width_inc;
              end
            end
          end
          if (scan_done) begin
            if (cyc_ok) begin
              state  <= S_DIV;
              op     <= OP_HIGH;
              div_go <= 1'b1;
            end else begin
              state                  <= S_LOAD;
              done                   <= 1'b1;
              result.high_width_x100 <= '0;
              result.low_width_x100  <= '0;
              result.period_x100     <= '0;
              result.duty_percent    <= '0;
              result.cycle_count     <= cyc_sat;
              result.window_max      <= running_max;
              result.window_min      <= running_min;
              result.overflow        <= overflow_flag;
              fill_count             <= '0;
              running_max            <= 8'd0;
              running_min            <= 8'd255;
              overflow_flag          <= 1'b0;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            unique case (op)
              OP_HIGH: begin
                hw     <= q_sat;
                op     <= OP_LOW;
                div_go <= 1'b1;
              end
              OP_LOW: begin
                lw     <= q_sat;
                op     <= OP_PER;
                div_go <= 1'b1;
              end
              OP_PER: begin
                result.period_x100 <= q_sat;
                op                 <= OP_DUTY;
                div_go             <= 1'b1;
              end
              OP_DUTY: begin
                state                  <= S_LOAD;
                done                   <= 1'b1;
                result.high_width_x100 <= hw;
                result.low_width_x100  <= lw;
                result.duty_percent    <= (tot_sum == '0) ? 7'd0 : 7'(quotient);
                result.cycle_count     <= cyc_sat;
                result.window_max      <= running_max;
                result.window_min      <= running_min;
                result.overflow        <= overflow_flag;
                fill_count             <= '0;
                running_max            <= 8'd0;
                running_min            <= 8'd255;
                overflow_flag          <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

FILE: hdl/wpt_checker.sv
// Port-level checks for the waveform pulse timing block, bound to the top level.
module wpt_checker
  import wpt_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input wpt_in_t  item,
  input logic     done,
  input wpt_out_t result
);

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.last) |=> busy)
    else $error("last sample did not start measurement");

  a_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("back-to-back result strobes");

  a_duty: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.duty_percent <= 7'd100))
    else $error("duty above 100 percent");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.cycle_count == 9'd0) |->
      (result.period_x100 == 16'd0 && result.duty_percent == 7'd0))
    else $error("nonzero averages with no cycles");

endmodule

bind waveform_pulse_timing wpt_checker u_wpt_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);
